// File: hdl/cnlc_pkg.sv
// ----------------------------------------------------------------------------
// Card number Luhn checker - shared definitions
// Character codes, dash layout positions, the per-character transaction type
// and the Luhn digit weighting function.
// ----------------------------------------------------------------------------
package cnlc_pkg;

    localparam logic [7:0] DASH_CODE  = 8'h2D;
    localparam logic [7:0] DIGIT_LO   = 8'h30;
    localparam logic [7:0] DIGIT_HI   = 8'h39;

    localparam int         POS_W      = 5;
    localparam logic [4:0] POS_MAX    = 5'd31;
    localparam logic [4:0] DASH_POS_A = 5'd4;
    localparam logic [4:0] DASH_POS_B = 5'd9;
    localparam logic [4:0] DASH_POS_C = 5'd14;

    localparam logic [2:0] DASH_MAX   = 3'd4;
    localparam logic [2:0] DASH_GROUP = 3'd3;

    localparam logic [4:0] LUHN_MOD   = 5'd10;

    typedef struct packed {
        logic       valid;
        logic [7:0] char_code;
        logic       last_char;
    } t_step;

    // Weighted Luhn contribution of one decimal digit
    function automatic logic [4:0] luhn_weight(input logic [3:0] digit, input logic dbl);
        logic [4:0] twice;
        twice = {digit, 1'b0};
        if (!dbl) begin
            return {1'b0, digit};
        end else if (twice >= LUHN_MOD) begin
            return twice - 5'd9;
        end else begin
            return twice;
        end
    endfunction

endpackage

// File: hdl/cnlc_accum.sv
// ----------------------------------------------------------------------------
// Card number Luhn checker - running state
// Holds position, dash count and layout flag, digit count and Luhn sum.
// Gives the verdict for the string whose last character is being stepped.
// ----------------------------------------------------------------------------
module cnlc_accum
    import cnlc_pkg::*;
#(
    parameter int CARD_DIGITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_step i_step,
    output logic  o_verdict
);

    localparam int CNT_W = $clog2(CARD_DIGITS + 2);
    localparam logic [CNT_W-1:0] DIGIT_SAT = CNT_W'(CARD_DIGITS + 1);
    localparam logic [CNT_W-1:0] DIGIT_REQ = CNT_W'(CARD_DIGITS);

    logic [POS_W-1:0] r_pos,   n_pos;
    logic [2:0]       r_dash,  n_dash;
    logic             r_lay,   n_lay;
    logic [CNT_W-1:0] r_digit, n_digit;
    logic [3:0]       r_sum,   n_sum;

    logic       is_dash;
    logic       is_digit;
    logic [4:0] weight;
    logic [4:0] sum_raw;
    logic       dashes_ok;

    always_comb begin
        is_dash  = (i_step.char_code == DASH_CODE);
        is_digit = (i_step.char_code >= DIGIT_LO) && (i_step.char_code <= DIGIT_HI);
        weight   = luhn_weight(i_step.char_code[3:0], ~r_digit[0]);
        sum_raw  = {1'b0, r_sum} + weight;

        n_pos   = (r_pos < POS_MAX) ? r_pos + 5'd1 : r_pos;
        n_dash  = r_dash;
        n_lay   = r_lay;
        n_digit = r_digit;
        n_sum   = r_sum;

        if (is_dash) begin
            if (r_dash < DASH_MAX) begin
                n_dash = r_dash + 3'd1;
            end
            if (r_pos != DASH_POS_A && r_pos != DASH_POS_B && r_pos != DASH_POS_C) begin
                n_lay = 1'b0;
            end
        end else if (is_digit) begin
            n_sum = (sum_raw >= LUHN_MOD) ? 4'(sum_raw - LUHN_MOD) : sum_raw[3:0];
            if (r_digit < DIGIT_SAT) begin
                n_digit = r_digit + CNT_W'(1);
            end
        end

        dashes_ok = (n_dash == 3'd0) || (n_dash == DASH_GROUP && n_lay);
        o_verdict = dashes_ok && (n_digit == DIGIT_REQ) && (n_sum == 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.valid && i_step.last_char)) begin
            r_pos   <= '0;
            r_dash  <= '0;
            r_lay   <= 1'b1;
            r_digit <= '0;
            r_sum   <= '0;
        end else if (i_step.valid) begin
            r_pos   <= n_pos;
            r_dash  <= n_dash;
            r_lay   <= n_lay;
            r_digit <= n_digit;
            r_sum   <= n_sum;
        end
    end

endmodule

// File: hdl/card_number_luhn_checker.sv
// ----------------------------------------------------------------------------
// An accepted last character passes the input and result registers to o_valid.
// Throughput: one character per cycle; the input register stalls only when it
// holds a last character and the result register is full and stalled.
// Reset (synchronous, active low) empties both registers and clears the
// running state; the next character starts a new string.
// ----------------------------------------------------------------------------
// Card number Luhn checker - top level
// Input register, running state update and result register.
// ----------------------------------------------------------------------------
module card_number_luhn_checker
    import cnlc_pkg::*;
#(
    parameter int CARD_DIGITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_card_valid
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       r_out_valid;
    logic       r_out_data;

    logic       advance;
    logic       accept;
    logic       verdict;
    t_step      step;

    assign advance = !r_in_last || !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    assign step.valid     = r_in_valid && advance;
    assign step.char_code = r_in_char;
    assign step.last_char = r_in_last;

    cnlc_accum #(
        .CARD_DIGITS (CARD_DIGITS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step.valid && step.last_char) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.valid && step.last_char) begin
            r_out_data <= verdict;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_card_valid = r_out_data;

endmodule

// File: hdl/cnlc_checker.sv
// ----------------------------------------------------------------------------
// Card number Luhn checker - port checker
// Concurrent assertions on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
module cnlc_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       o_stall,
    input  logic       i_last_char,
    input  logic       o_valid,
    input  logic       i_stall,
    input  logic       o_card_valid
);

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not idle after reset");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_card_valid))
        else $error("stalled result transaction changed");

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

    a_last_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && i_valid && !o_stall && i_last_char |=> ##1 o_valid)
        else $error("last character produced no result");

endmodule

bind card_number_luhn_checker cnlc_checker u_cnlc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_last_char  (i_last_char),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_card_valid (o_card_valid)
);

// File: verif/tb_card_number_luhn_checker.sv
// ----------------------------------------------------------------------------
// Card number Luhn checker - testbench
// Sends card strings one character per transaction and tracks the dash
// layout, digit count and Luhn sum of each string. The expected verdict is
// queued on the marked last character and compared with every verdict the
// block returns. Clean cards, dashed cards, broken cards, long strings and
// byte noise are sent, with random idling on both sides, a long output
// hold-off and a stretch without idling.
// ----------------------------------------------------------------------------
module tb_card_number_luhn_checker;
    import cnlc_pkg::*;

    localparam int CARD_DIGITS   = 16;
    localparam int IDLE_PCT      = 37;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 3000;

    typedef enum int {
        SHAPE_BAD_DIGIT,
        SHAPE_EXTRA_DIGITS,
        SHAPE_DROPPED_CHAR,
        SHAPE_EXTRA_DASHES,
        SHAPE_LONG,
        SHAPE_NOISE
    } t_shape;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_char_code = 8'h00;
    logic       i_last_char = 1'b0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_card_valid;

    logic       expected_verdicts[$];
    logic [7:0] card_str[$];

    logic [4:0] cur_pos    = '0;
    logic [2:0] cur_dashes = '0;
    logic       layout_ok  = 1'b1;
    logic [4:0] cur_digits = '0;
    logic [3:0] cur_sum    = '0;

    int         errors       = 0;
    int         chars_sent   = 0;
    int         quiet_cycles = 0;
    int         holds_asked  = 0;
    int         holds_done   = 0;
    int         hold_left    = 0;
    bit         calm         = 1'b0;

    card_number_luhn_checker #(
        .CARD_DIGITS (CARD_DIGITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_code  (i_char_code),
        .i_last_char  (i_last_char),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_card_valid (o_card_valid)
    );

    always #5 i_clk = ~i_clk;

    function automatic int luhn_term(input int digit, input bit doubled);
        if (!doubled) begin
            return digit;
        end
        return (2 * digit >= 10) ? 2 * digit - 9 : 2 * digit;
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (c == DASH_CODE || (c >= DIGIT_LO && c <= DIGIT_HI));
        return c;
    endfunction

    task automatic append_char(input logic [7:0] c);
        card_str = {card_str, c};
    endtask

    task automatic luhn_track_char(input logic [7:0] c, input logic last);
        logic verdict;
        if (c == DASH_CODE) begin
            if (cur_dashes < DASH_MAX) begin
                cur_dashes = cur_dashes + 3'd1;
            end
            if (cur_pos != DASH_POS_A && cur_pos != DASH_POS_B && cur_pos != DASH_POS_C) begin
                layout_ok = 1'b0;
            end
        end else if (c >= DIGIT_LO && c <= DIGIT_HI) begin
            cur_sum = 4'((int'(cur_sum)
                          + luhn_term(int'(c - DIGIT_LO), cur_digits[0] == 1'b0)) % 10);
            if (cur_digits < CARD_DIGITS + 1) begin
                cur_digits = cur_digits + 5'd1;
            end
        end
        if (cur_pos < POS_MAX) begin
            cur_pos = cur_pos + 5'd1;
        end
        if (last) begin
            verdict = (cur_dashes == 3'd0 || (cur_dashes == DASH_GROUP && layout_ok))
                      && cur_digits == CARD_DIGITS && cur_sum == 4'd0;
            expected_verdicts = {expected_verdicts, verdict};
            cur_pos    = '0;
            cur_dashes = '0;
            layout_ok  = 1'b1;
            cur_digits = '0;
            cur_sum    = '0;
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        luhn_track_char(c, last);
        chars_sent++;
    endtask

    task automatic send_string();
        foreach (card_str[i]) begin
            send_char(card_str[i], i == card_str.size() - 1);
        end
    endtask

    task automatic build_card(input bit dashed);
        int digit;
        int total;
        card_str.delete();
        total = 0;
        for (int i = 0; i < CARD_DIGITS; i++) begin
            if (i == CARD_DIGITS - 1) begin
                digit = (10 - total % 10) % 10;
            end else begin
                digit = $urandom_range(9);
                total += luhn_term(digit, i % 2 == 0);
            end
            if (dashed && i != 0 && i % 4 == 0) begin
                append_char(DASH_CODE);
            end
            append_char(8'(int'(DIGIT_LO) + digit));
        end
    endtask

    task automatic build_test_string();
        t_shape shape;
        int     idx;
        if ($urandom_range(99) < 55) begin
            build_card(1'($urandom_range(1)));
            if ($urandom_range(2) == 0) begin
                card_str.insert($urandom_range(card_str.size() - 1), noise_char());
            end
            return;
        end
        shape = t_shape'($urandom_range(SHAPE_NOISE));
        if (shape != SHAPE_NOISE) begin
            build_card(1'($urandom_range(1)));
        end
        case (shape)
            SHAPE_BAD_DIGIT: begin
                idx = $urandom_range(card_str.size() - 1);
                if (card_str[idx] != DASH_CODE) begin
                    card_str[idx] = 8'(DIGIT_LO
                                    + (card_str[idx] - DIGIT_LO + $urandom_range(1, 9)) % 10);
                end
            end
            SHAPE_EXTRA_DIGITS: begin
                repeat ($urandom_range(1, 8)) append_char(8'(DIGIT_LO + $urandom_range(9)));
            end
            SHAPE_DROPPED_CHAR: begin
                card_str.delete($urandom_range(card_str.size() - 1));
            end
            SHAPE_EXTRA_DASHES: begin
                repeat ($urandom_range(1, 3)) begin
                    card_str.insert($urandom_range(card_str.size() - 1), DASH_CODE);
                end
            end
            SHAPE_LONG: begin
                repeat ($urandom_range(16, 30)) card_str.push_front(noise_char());
                if ($urandom_range(1) == 1) begin
                    card_str.insert($urandom_range(card_str.size() - 1), DASH_CODE);
                end
            end
            SHAPE_NOISE: begin
                card_str.delete();
                repeat ($urandom_range(1, 40)) begin
                    case ($urandom_range(4))
                        0:       append_char(DASH_CODE);
                        1:       append_char(8'(DIGIT_LO + $urandom_range(9)));
                        default: append_char(8'($urandom_range(255)));
                    endcase
                end
            end
        endcase
    endtask

    task automatic settle_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_single_chars();
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(DASH_CODE, 1'b1);
        send_char(DIGIT_LO, 1'b1);
        send_char(DIGIT_HI, 1'b1);
        send_char(DIGIT_LO - 8'd1, 1'b1);
        send_char(DIGIT_HI + 8'd1, 1'b1);
    endtask

    task automatic test_plain_card();
        build_card(1'b0);
        send_string();
    endtask

    task automatic test_random_strings(input int budget);
        int stop_at;
        stop_at = chars_sent + budget;
        while (chars_sent < stop_at) begin
            build_test_string();
            send_string();
        end
    endtask

    task automatic test_no_idle();
        calm = 1'b1;
        test_random_strings(150);
        calm = 1'b0;
    endtask

    task automatic test_output_hold();
        calm = 1'b1;
        holds_asked++;
        repeat (24) send_char(8'($urandom_range(255)), 1'b1);
        calm = 1'b0;
        settle_results();
    endtask

    // receiver: random stall, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            i_stall    <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_asked;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : verdict_check
        logic want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict: expected none, actual %0b",
                         $time, o_card_valid);
                errors++;
            end else begin
                want = expected_verdicts.pop_front();
                if (o_card_valid !== want) begin
                    $display("%0t: card_valid mismatch: expected %0b, actual %0b",
                             $time, want, o_card_valid);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("** card_number_luhn_checker: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_chars();
        test_plain_card();
        test_random_strings(900);
        test_no_idle();
        test_output_hold();
        test_random_strings(100);
        settle_results();
        if (errors == 0) begin
            $display("** card_number_luhn_checker: PASSED **");
        end else begin
            $display("** card_number_luhn_checker: FAILED **");
        end
        $finish;
    end

endmodule
